// ----- design/vgr_pkg.sv -----
package vgr_pkg;

  localparam int unsigned DataW     = 64;
  localparam int unsigned FifoDepth = 2;

  // one classified element on its way from front to back
  typedef struct packed {
    logic [DataW-1:0] element;
    logic [DataW-1:0] mag;
    logic             zero;
    logic             last;
  } item_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quot;
    logic [DataW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD_START,
    S_GCD_WAIT,
    S_RD,
    S_RD_WAIT,
    S_DIV_WAIT,
    S_PUT
  } state_t;

  // magnitude of a two's complement word, most negative wraps to 2^63
  function automatic logic [DataW-1:0] mag_of(input logic [DataW-1:0] v);
    mag_of = v[DataW-1] ? (~v + {{(DataW-1){1'b0}}, 1'b1}) : v;
  endfunction

endpackage

// ----- design/vgr_ram.sv -----
module vgr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/vgr_fifo.sv -----
module vgr_fifo
  import vgr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  localparam int unsigned PW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CW = $clog2(FifoDepth + 1);

  item_t         mem_r [FifoDepth];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(FifoDepth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(FifoDepth - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(FifoDepth - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ----- design/vgr_front.sv -----
module vgr_front
  import vgr_pkg::*;
(
  input  logic             in_push,
  input  logic [DataW-1:0] in_element,
  input  logic             in_last_in,
  input  logic             q_full,
  output logic             in_full,
  output logic             q_push,
  output item_t            q_item
);

  // classify the incoming beat and hand it to the queue
  assign in_full        = q_full;
  assign q_push         = in_push;
  assign q_item.element = in_element;
  assign q_item.mag     = mag_of(in_element);
  assign q_item.zero    = (in_element == '0);
  assign q_item.last    = in_last_in;

endmodule

// ----- design/vgr_divider.sv -----
module vgr_divider
  import vgr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned StepW = $clog2(DataW);

  logic [DataW:0]   rem_r, rem_nxt;
  logic [DataW-1:0] quot_r, quot_nxt;
  logic [DataW-1:0] dsr_r;
  logic [StepW-1:0] step_r;
  logic             busy_r, done_r;
  logic [DataW:0]   shifted, diff;

  // one restoring step per cycle
  always_comb begin
    shifted  = {rem_r[DataW-1:0], quot_r[DataW-1]};
    diff     = shifted - {1'b0, dsr_r};
    quot_nxt = {quot_r[DataW-2:0], !diff[DataW]};
    rem_nxt  = diff[DataW] ? shifted : diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == StepW'(DataW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      quot_r <= req.dividend;
      dsr_r  <= req.divisor;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r[DataW-1:0];

endmodule

// ----- design/vgr_back.sv -----
module vgr_back
  import vgr_pkg::*;
#(
  parameter int unsigned VECTOR_MAX = 32,
  localparam int unsigned AW = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1,
  localparam int unsigned CW = $clog2(VECTOR_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  item_t            q_item,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [DataW-1:0] ram_wdata,
  output logic [AW-1:0]    ram_raddr,
  input  logic [DataW-1:0] ram_rdata,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [DataW-1:0] out_reduced,
  output logic             out_last_out
);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [DataW-1:0] div_r, div_nxt;
  logic [DataW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [DataW-1:0] res_r, res_nxt;
  logic             neg_r, neg_nxt;
  logic             last_r, last_nxt;
  logic             ov_r, ov_nxt;
  logic [DataW-1:0] ored_r, ored_nxt;
  logic             olast_r, olast_nxt;
  logic             store, out_free, put, is_final;

  assign store    = (count_r < CW'(VECTOR_MAX));
  assign out_free = !ov_r || out_pop;
  assign is_final = (idx_r == count_r - 1'b1);
  assign put      = (state_r == S_PUT) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          if (store && !q_item.zero) begin
            state_nxt = S_GCD_START;
          end else if (q_item.last) begin
            state_nxt = S_RD;
          end
        end
      end
      S_GCD_START: begin
        if (b_r == '0) begin
          state_nxt = last_r ? S_RD : S_IDLE;
        end else begin
          state_nxt = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: if (div_rsp.done) state_nxt = S_GCD_START;
      S_RD:       state_nxt = S_RD_WAIT;
      S_RD_WAIT: begin
        if (ram_rdata == '0 || div_r == '0) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: if (div_rsp.done) state_nxt = S_PUT;
      S_PUT: begin
        if (out_free) begin
          state_nxt = is_final ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    div_nxt   = div_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    neg_nxt   = neg_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = q_item.element;
    ram_raddr = idx_r[AW-1:0];
    div_req   = '0;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (!q_empty) begin
          q_pop    = 1'b1;
          last_nxt = q_item.last;
          if (store) begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
            a_nxt     = div_r;
            b_nxt     = q_item.mag;
          end
        end
      end
      S_GCD_START: begin
        if (b_r == '0) begin
          div_nxt = a_r;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = a_r;
          div_req.divisor  = b_r;
        end
      end
      S_GCD_WAIT: begin
        if (div_rsp.done) begin
          a_nxt = b_r;
          b_nxt = div_rsp.rem;
        end
      end
      S_RD: ;
      S_RD_WAIT: begin
        neg_nxt = ram_rdata[DataW-1];
        if (ram_rdata == '0 || div_r == '0) begin
          res_nxt = ram_rdata;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = mag_of(ram_rdata);
          div_req.divisor  = div_r;
        end
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          res_nxt = neg_r ? (~div_rsp.quot + 1'b1) : div_rsp.quot;
        end
      end
      S_PUT: begin
        if (out_free) begin
          if (is_final) begin
            count_nxt = '0;
            div_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // result register, one beat waiting
  always_comb begin
    ov_nxt    = ov_r && !out_pop;
    ored_nxt  = ored_r;
    olast_nxt = olast_r;
    if (put) begin
      ov_nxt    = 1'b1;
      ored_nxt  = res_r;
      olast_nxt = is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      div_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      div_r   <= div_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    res_r   <= res_nxt;
    neg_r   <= neg_nxt;
    last_r  <= last_nxt;
    ored_r  <= ored_nxt;
    olast_r <= olast_nxt;
  end

  assign out_empty    = !ov_r;
  assign out_reduced  = ored_r;
  assign out_last_out = olast_r;

`ifndef SYNTHESIS
  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> count_r < CW'(VECTOR_MAX))
    else $error("store written while full");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_req.divisor != '0)
    else $error("divide by zero started");
  a_vector_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (put && is_final) |=> (count_r == '0 && div_r == '0))
    else $error("vector state not cleared after final beat");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_pop) |=> $stable(out_reduced))
    else $error("waiting result overwritten");
`endif

endmodule

// ----- design/vector_gcd_reduce_unit.sv -----
// Vector gcd reduction. Elements arrive one beat each with last_in on the
// final one; each accepted element is stored and its magnitude folded into
// a running gcd by Euclid's remainder steps on one shared 64-bit restoring
// divider; a zero element is stored without a divide. On the final element
// every stored element is sent out divided exactly by the gcd with its sign
// kept, one divide per beat (none for a zero element or an all-zero vector).
// Up to VECTOR_MAX elements are kept; further ones are dropped.
// A two-entry queue decouples input from the sequencer, which takes the next
// element only once the previous one is fully folded in.
module vector_gcd_reduce_unit
  import vgr_pkg::*;
#(
  parameter int unsigned VECTOR_MAX = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [DataW-1:0] in_element,
  input  logic             in_last_in,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [DataW-1:0] out_reduced,
  output logic             out_last_out
);

  localparam int unsigned AW = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1;

  item_t            f_item, q_item;
  logic             f_push, q_full, q_empty, q_pop;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // front: classify incoming beats
  vgr_front u_front (
    .in_push    (in_push),
    .in_element (in_element),
    .in_last_in (in_last_in),
    .q_full     (q_full),
    .in_full    (in_full),
    .q_push     (f_push),
    .q_item     (f_item)
  );

  // queue between front and back
  vgr_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  // element store
  vgr_ram #(
    .WIDTH (DataW),
    .DEPTH (VECTOR_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared divider for gcd and reduction
  vgr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // back: gcd fold and output sequencing
  vgr_back #(
    .VECTOR_MAX (VECTOR_MAX)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_item       (q_item),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_reduced  (out_reduced),
    .out_last_out (out_last_out)
  );

endmodule
